>>> rtl/core/dfhe_pkg.sv
package dfhe_pkg;

   localparam int unsigned MAX_DISTANCE = 32768;
   localparam int unsigned LEN_MIN      = 3;
   localparam int unsigned LEN_MAX      = 258;

   localparam logic [7:0] ZLIB_CMF = 8'h78;
   localparam logic [7:0] ZLIB_FLG = 8'h01;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_LIT    = 2'd1,
      OP_MATCH  = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  lit;
      logic [8:0]  len;
      logic [15:0] distance;
   } dfhe_token_type;

   // up to four bytes for one token, first byte in the low bits
   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        has_bytes;
      logic        error;
   } dfhe_burst_type;

endpackage

>>> rtl/core/dfhe_coder.sv
module dfhe_coder (
   input  dfhe_pkg::dfhe_token_type tok,
   input  logic [6:0]               pend_bits,
   input  logic [2:0]               pend_cnt,
   output dfhe_pkg::dfhe_burst_type burst,
   output logic [6:0]               next_bits,
   output logic [2:0]               next_cnt
);
   import dfhe_pkg::*;

   function automatic logic [3:0] msb15(input logic [14:0] v);
      logic [3:0] m;
      m = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (v[i]) m = 4'(i);
      end
      return m;
   endfunction

   // reverse the low n bits of a code of up to nine bits
   function automatic logic [8:0] rev_code(input logic [8:0] v, input logic [3:0] n);
      logic [8:0] full;
      for (int i = 0; i < 9; i++) begin
         full[i] = v[8-i];
      end
      return full >> (4'd9 - n);
   endfunction

   logic        len_ok;
   logic        dist_ok;
   logic [7:0]  l;
   logic [2:0]  lp;
   logic [4:0]  li;
   logic [4:0]  lx_val;
   logic [2:0]  lx_n;
   logic [14:0] d;
   logic [3:0]  dp;
   logic [4:0]  di;
   logic [12:0] dx_val;
   logic [3:0]  dx_n;
   logic [8:0]  code;
   logic [3:0]  code_n;
   logic [37:0] acc;
   logic [5:0]  pos;
   logic [2:0]  nfull;
   logic        flush;
   logic [2:0]  count;
   logic [37:0] rest;

   always_comb begin
      len_ok  = (tok.len >= 9'(LEN_MIN)) && (tok.len <= 9'(LEN_MAX));
      dist_ok = (tok.distance != 16'd0) && ({1'b0, tok.distance} <= 17'(MAX_DISTANCE));

      // length symbol index and extra bits
      l  = 8'(tok.len - 9'(LEN_MIN));
      lp = 3'(msb15({7'd0, l}));
      if (tok.len == 9'(LEN_MAX)) begin
         li     = 5'd28;
         lx_n   = 3'd0;
         lx_val = 5'd0;
      end else if (l < 8'd8) begin
         li     = l[4:0];
         lx_n   = 3'd0;
         lx_val = 5'd0;
      end else begin
         lx_n   = 3'(lp - 3'd2);
         li     = 5'({lp - 3'd1, 2'b00}) + 5'(2'(l >> lx_n));
         lx_val = 5'(l & ((8'd1 << lx_n) - 8'd1));
      end

      // distance code and extra bits
      d  = 15'(tok.distance - 16'd1);
      dp = msb15(d);
      if (d < 15'd4) begin
         di     = d[4:0];
         dx_n   = 4'd0;
         dx_val = 13'd0;
      end else begin
         dx_n   = 4'(dp - 4'd1);
         di     = {dp, 1'b0} + 5'(d[dx_n]);
         dx_val = 13'(d & ((15'd1 << dx_n) - 15'd1));
      end

      // fixed huffman code of the leading symbol
      case (tok.op)
         OP_LIT: begin
            if (tok.lit <= 8'd143) begin
               code   = 9'(8'h30 + tok.lit);
               code_n = 4'd8;
            end else begin
               code   = 9'h190 + 9'(tok.lit - 8'd144);
               code_n = 4'd9;
            end
         end
         OP_MATCH: begin
            if (li <= 5'd22) begin
               code   = 9'(li + 5'd1);
               code_n = 4'd7;
            end else begin
               code   = 9'h0c0 + 9'(li - 5'd23);
               code_n = 4'd8;
            end
         end
         default: begin
            // end of block is seven zero bits
            code   = 9'd0;
            code_n = 4'd7;
         end
      endcase

      acc = 38'(pend_bits);
      pos = 6'(pend_cnt);
      acc = acc | (38'(rev_code(code, code_n)) << pos);
      pos = pos + 6'(code_n);
      if (tok.op == OP_MATCH) begin
         acc = acc | (38'(lx_val) << pos);
         pos = pos + 6'(lx_n);
         acc = acc | (38'({di[0], di[1], di[2], di[3], di[4]}) << pos);
         pos = pos + 6'd5;
         acc = acc | (38'(dx_val) << pos);
         pos = pos + 6'(dx_n);
      end

      nfull = pos[5:3];
      flush = (tok.op == OP_FINISH) && (pos[2:0] != 3'd0);
      count = nfull + 3'(flush);
      rest  = acc >> {nfull, 3'b000};

      burst.error = 1'b0;
      if (tok.op == OP_BEGIN) begin
         // header bytes, then block header bits bfinal=1 btype=01
         burst.bytes     = {16'd0, ZLIB_FLG, ZLIB_CMF};
         burst.count     = 3'd2;
         burst.has_bytes = 1'b1;
         next_bits       = 7'd3;
         next_cnt        = 3'd3;
      end else if (tok.op == OP_MATCH && !(len_ok && dist_ok)) begin
         burst.bytes     = 32'd0;
         burst.count     = 3'd1;
         burst.has_bytes = 1'b0;
         burst.error     = 1'b1;
         next_bits       = pend_bits;
         next_cnt        = pend_cnt;
      end else begin
         burst.bytes     = acc[31:0];
         burst.has_bytes = (count != 3'd0);
         burst.count     = (count != 3'd0) ? count : 3'd1;
         next_bits       = flush ? 7'd0 : rest[6:0];
         next_cnt        = flush ? 3'd0 : pos[2:0];
      end
   end

endmodule

>>> rtl/core/deflate_fixed_huffman_encoder.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  operation, literal_byte, match_length,
//                                             match_distance
// rsp_      out        rsp_valid / rsp_ready  out_byte, byte_valid, last, error
//
// a token is held in the input register, is coded by dfhe_coder into a byte
// burst register, and leaves as 1 to 4 transactions, one byte per cycle while
// rsp_ready is high, the pace set by the single byte output port; a new token is
// coded in the cycle the last byte goes
// reset clears the valid flags and the pending bit buffer
// rsp_ready low holds the burst and, behind it, the input register
module deflate_fixed_huffman_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_literal_byte,
   input  logic [8:0]  req_match_length,
   input  logic [15:0] req_match_distance,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic        rsp_error
);
   import dfhe_pkg::*;

   logic           in_valid_ff, in_valid_in;
   dfhe_token_type in_tok_ff, in_tok_in;
   logic           busy_ff, busy_in;
   logic [2:0]     left_ff, left_in;
   logic [31:0]    bytes_ff, bytes_in;
   logic           has_bytes_ff, has_bytes_in;
   logic           error_ff, error_in;
   logic [6:0]     pend_bits_ff, pend_bits_in;
   logic [2:0]     pend_cnt_ff, pend_cnt_in;

   dfhe_burst_type burst;
   logic [6:0]     next_bits;
   logic [2:0]     next_cnt;
   logic           drain;
   logic           drain_last;
   logic           load;

   dfhe_coder u_coder (
      .tok       (in_tok_ff),
      .pend_bits (pend_bits_ff),
      .pend_cnt  (pend_cnt_ff),
      .burst     (burst),
      .next_bits (next_bits),
      .next_cnt  (next_cnt)
   );

   assign rsp_valid      = busy_ff;
   assign rsp_out_byte   = bytes_ff[7:0];
   assign rsp_byte_valid = has_bytes_ff;
   assign rsp_last       = (left_ff == 3'd1);
   assign rsp_error      = error_ff;

   assign drain      = busy_ff && rsp_ready;
   assign drain_last = drain && (left_ff == 3'd1);
   assign load       = in_valid_ff && (!busy_ff || drain_last);
   assign req_ready  = !in_valid_ff || load;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_tok_in    = in_tok_ff;
      busy_in      = busy_ff;
      left_in      = left_ff;
      bytes_in     = bytes_ff;
      has_bytes_in = has_bytes_ff;
      error_in     = error_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;

      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in         = 1'b1;
         in_tok_in.op        = op_type'(req_operation);
         in_tok_in.lit       = req_literal_byte;
         in_tok_in.len       = req_match_length;
         in_tok_in.distance  = req_match_distance;
      end

      if (load) begin
         busy_in      = 1'b1;
         left_in      = burst.count;
         bytes_in     = burst.bytes;
         has_bytes_in = burst.has_bytes;
         error_in     = burst.error;
         pend_bits_in = next_bits;
         pend_cnt_in  = next_cnt;
      end else if (drain_last) begin
         busy_in = 1'b0;
      end else if (drain) begin
         left_in  = left_ff - 3'd1;
         bytes_in = bytes_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         pend_bits_ff <= 7'd0;
         pend_cnt_ff  <= 3'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         busy_ff      <= busy_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_tok_ff    <= in_tok_in;
      left_ff      <= left_in;
      bytes_ff     <= bytes_in;
      has_bytes_ff <= has_bytes_in;
      error_ff     <= error_in;
   end

endmodule
